// File: hw/rtl/ffdl_pkg.sv
// Shared types and constants for the fractional feedback delay line.
`timescale 1ns / 1ps

package ffdl_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic [19:0]        delay_t;
  typedef logic [15:0]        gain_t;

  localparam int    FRAC_BITS   = 8;
  localparam gain_t GAIN_RESET  = 16'd16384;  // 1.0 in Q2.14
  localparam int    ROUND_SHIFT = 22;

  localparam logic  REG_LOOP_GAIN = 1'b0;  // word index of loop_gain

  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = -16'sh8000;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RDB  = 5'b00010,
    S_MUL1 = 5'b00100,
    S_MUL2 = 5'b01000,
    S_WR   = 5'b10000
  } state_t;

endpackage

// File: hw/rtl/ffdl_if.sv
// Valid/ready channel interfaces for delay line input and result words.
`timescale 1ns / 1ps

interface ffdl_in_if
  import ffdl_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t sample_in;
  delay_t  delay_samples;

  modport source (output valid, output sample_in, output delay_samples, input ready);
  modport sink   (input valid, input sample_in, input delay_samples, output ready);
endinterface

interface ffdl_out_if
  import ffdl_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// File: hw/rtl/fractional_feedback_delay_line.sv
// Top level: fractional feedback delay line on a single-port-read ring memory.
`timescale 1ns / 1ps

// Feedback delay line with linear interpolation. Each input word carries a
// 16-bit sample and a delay in samples (8 fraction bits), clamped to
// 1..DEPTH-1. The two ring entries around the delay are read, blended by the
// fraction, scaled by the Q2.14 loop_gain register (reset 1.0), rounded
// (ties up) and saturated; that is the result word. Input plus result,
// saturated, is written as the newest ring entry. The next word is not
// accepted until write-back: the accept cycle issues the read of the
// nearer tap, the farther tap follows over the same memory read port,
// and the interpolation multiply, gain multiply and write-back with
// round/saturate each have a state. A result waiting in the output
// register does not block acceptance; only the write-back cycle waits for
// the output register to be free. The ring is never swept after reset: a
// fill count marks entries not yet written since reset, and those read as
// silence, so the block is ready in the first cycle after reset.
module fractional_feedback_delay_line
  import ffdl_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  ffdl_in_if.sink     in_ch,
  ffdl_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(DEPTH);
  localparam int DW = (AW + FRAC_BITS > 20) ? AW + FRAC_BITS : 20;
  localparam logic [AW:0]   DEPTH_V = (AW + 1)'(DEPTH);
  localparam logic [DW-1:0] DMIN    = DW'(256);
  localparam logic [DW-1:0] DMAX    = DW'((DEPTH - 1) * 256);

  // ring memory
  sample_t         ring_mem [DEPTH];
  sample_t         ring_rdata_r;
  logic            ring_re;
  logic [AW-1:0]   ring_raddr;
  logic            ring_we;

  // control
  state_t          state_r, state_nxt;
  logic [AW-1:0]   wi_r, wi_nxt;
  logic [AW:0]     fill_r, fill_nxt;
  gain_t           gain_r, gain_nxt;
  logic            out_valid_r, out_valid_nxt;

  // payload
  sample_t         x_r, x_nxt;
  logic [AW-1:0]   n_r, n_nxt;
  logic [7:0]      f_r, f_nxt;
  sample_t         a_r, a_nxt;
  logic            b_ok_r, b_ok_nxt;
  logic signed [24:0] interp_r, interp_nxt;
  logic signed [40:0] prod_r, prod_nxt;
  sample_t         out_data_r, out_data_nxt;

  // datapath temporaries
  logic [DW-1:0]   d_ext, d_cl;
  logic [AW-1:0]   n_in;
  logic [AW:0]     diff_a, diff_b, n_ext;
  logic [AW-1:0]   slot_a, slot_b;
  sample_t         b_val;
  logic signed [16:0] ba_diff;
  logic signed [25:0] blend;
  logic signed [41:0] prod_full;
  logic signed [40:0] rounded;
  logic signed [18:0] y_q;
  sample_t         res;
  logic signed [16:0] wsum;
  sample_t         wr_val;
  logic            accept, wr_go, cfg_wr;

  assign accept = in_ch.valid && in_ch.ready;
  assign wr_go  = (state_r == S_WR) && (!out_valid_r || out_ch.ready);
  assign cfg_wr = psel && penable && pwrite && pready;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;
  assign pready            = 1'b1;
  assign prdata            = (paddr[2] == REG_LOOP_GAIN) ? {16'd0, gain_r} : 32'd0;

  // Delay clamp on the incoming word; feeds the nearer-tap address directly.
  always_comb begin
    d_ext = DW'(in_ch.delay_samples);
    priority if (d_ext < DMIN) begin
      d_cl = DMIN;
    end else if (d_ext > DMAX) begin
      d_cl = DMAX;
    end else begin
      d_cl = d_ext;
    end
    n_in = d_cl[AW+FRAC_BITS-1:FRAC_BITS];
  end

  // Slot addresses: write index minus steps, wrapped modulo DEPTH.
  always_comb begin
    n_ext  = {1'b0, n_r};
    diff_a = {1'b0, wi_r} - {1'b0, n_in};
    slot_a = diff_a[AW] ? AW'(diff_a + DEPTH_V) : diff_a[AW-1:0];
    diff_b = {1'b0, wi_r} - (n_ext + 1'b1);
    slot_b = diff_b[AW] ? AW'(diff_b + DEPTH_V) : diff_b[AW-1:0];
  end

  assign ring_re    = accept || (state_r == S_RDB);
  assign ring_raddr = (state_r == S_RDB) ? slot_b : slot_a;
  assign ring_we    = wr_go;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wi_r] <= wr_val;
    end
    if (ring_re) begin
      ring_rdata_r <= ring_mem[ring_raddr];
    end
  end

  // Arithmetic: interp = a*256 + (b - a)*f, then times gain, round, saturate.
  always_comb begin
    b_val     = b_ok_r ? ring_rdata_r : '0;
    ba_diff   = 17'(b_val) - 17'(a_r);
    blend     = 26'(ba_diff * $signed({1'b0, f_r})) + (26'(a_r) <<< FRAC_BITS);
    prod_full = interp_r * $signed({1'b0, gain_r});
    rounded   = (prod_r + 41'sd2097152) >>> ROUND_SHIFT;
    y_q       = rounded[18:0];
    priority if (y_q > 19'(SAMPLE_MAX)) begin
      res = SAMPLE_MAX;
    end else if (y_q < 19'(SAMPLE_MIN)) begin
      res = SAMPLE_MIN;
    end else begin
      res = y_q[15:0];
    end
    wsum = 17'(x_r) + 17'(res);
    priority if (wsum > 17'(SAMPLE_MAX)) begin
      wr_val = SAMPLE_MAX;
    end else if (wsum < 17'(SAMPLE_MIN)) begin
      wr_val = SAMPLE_MIN;
    end else begin
      wr_val = wsum[15:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wi_nxt        = wi_r;
    fill_nxt      = fill_r;
    gain_nxt      = gain_r;
    out_valid_nxt = out_valid_r;
    x_nxt         = x_r;
    n_nxt         = n_r;
    f_nxt         = f_r;
    a_nxt         = a_r;
    b_ok_nxt      = b_ok_r;
    interp_nxt    = interp_r;
    prod_nxt      = prod_r;
    out_data_nxt  = out_data_r;

    if (cfg_wr && (paddr[2] == REG_LOOP_GAIN)) begin
      gain_nxt = pwdata[15:0];
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          x_nxt     = in_ch.sample_in;
          n_nxt     = n_in;
          f_nxt     = d_cl[FRAC_BITS-1:0];
          state_nxt = S_RDB;
        end
      end
      S_RDB: begin
        // nearer tap is on the read port now; unwritten entries are silence
        a_nxt     = (n_ext <= fill_r) ? ring_rdata_r : '0;
        b_ok_nxt  = ((n_ext + 1'b1) <= fill_r);
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        interp_nxt = blend[24:0];
        state_nxt  = S_MUL2;
      end
      S_MUL2: begin
        prod_nxt  = prod_full[40:0];
        state_nxt = S_WR;
      end
      S_WR: begin
        if (wr_go) begin
          out_data_nxt  = res;
          out_valid_nxt = 1'b1;
          wi_nxt        = (wi_r == AW'(DEPTH - 1)) ? '0 : wi_r + 1'b1;
          if (fill_r != DEPTH_V) begin
            fill_nxt = fill_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wi_r        <= '0;
      fill_r      <= '0;
      gain_r      <= GAIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wi_r        <= wi_nxt;
      fill_r      <= fill_nxt;
      gain_r      <= gain_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r        <= x_nxt;
    n_r        <= n_nxt;
    f_r        <= f_nxt;
    a_r        <= a_nxt;
    b_ok_r     <= b_ok_nxt;
    interp_r   <= interp_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  // One word in flight: the cycle after an accept the input is closed.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("input accepted while a word is in flight");

  // Write-back always leaves a result in the output register.
  a_wb_result: assert property (@(posedge clk) disable iff (!rst_n)
    wr_go |=> out_valid_r)
    else $error("write-back without result word");

  // Fill count and write index advance together and stay in range.
  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    wr_go |=> (fill_r == DEPTH_V) || (fill_r == $past(fill_r) + 1'b1))
    else $error("fill count out of step with writes");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= DEPTH_V) && (32'(wi_r) < DEPTH))
    else $error("ring pointer out of range");

endmodule

// File: tb/tb_fractional_feedback_delay_line.sv
// Self-checking testbench for the fractional feedback delay line.
`timescale 1ns / 1ps

// Drives sample/delay words into the block and checks every result word
// against a local model of the ring, the clamped fractional tap, the
// Q2.14 loop gain and the saturating write-back. The loop gain register
// is written over the APB-style port only while the block is drained.
module tb_fractional_feedback_delay_line
  import ffdl_pkg::*;
();

  localparam int  DEPTH         = 4096;
  localparam longint DELAY_MAX  = longint'(DEPTH - 1) * 256;  // clamp ceiling
  localparam int  SETTLE_CYCLES = 12;     // idle time after the last result word
  localparam int  HOLD_AT       = 200;    // accepted words before the long sink hold
  localparam int  HOLD_CYCLES   = 250;
  localparam int  NUM_PHASES    = 7;
  localparam longint LIMIT_NS   = 3_000_000;

  // Register map: loop_gain is word 0; word 1 has no register behind it.
  localparam logic [2:0] GAIN_ADDR  = {REG_LOOP_GAIN, 2'b00};
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  typedef struct {
    sample_t sample;
    delay_t  delay;
  } feed_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ffdl_in_if  in_ch ();
  ffdl_out_if out_ch ();

  fractional_feedback_delay_line #(
    .DEPTH (DEPTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Local copy of the block state: ring contents, write pointer, gain.
  sample_t ring_model [DEPTH];
  int      wr_ptr;
  gain_t   gain_model;

  feed_t   pending_words [$];   // words waiting for the driver
  sample_t expected_out  [$];   // predicted result words, oldest first
  int      words_queued;
  int      words_accepted;
  int      err_count;

  // Idle controls; the sequencer sets the enables between phases.
  bit      src_idle_en;
  bit      sink_idle_en;
  int      src_gap;
  int      sink_stall;
  int      hold_left;
  bit      hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("tb_fractional_feedback_delay_line: errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  function automatic sample_t clip16(longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return sample_t'(v);
  endfunction

  // One word through the delay line: clamp the delay, blend the two taps
  // around it, apply the gain with round-half-up, saturate, then write the
  // saturated input+output back as the newest ring entry.
  function automatic sample_t tap_blend(sample_t x, delay_t d);
    longint dc;
    longint n;
    longint f;
    longint near_tap;
    longint far_tap;
    longint mix;
    longint scaled;
    sample_t res;
    dc = longint'(d);
    if (dc < 256) dc = 256;
    if (dc > DELAY_MAX) dc = DELAY_MAX;
    n = dc >> FRAC_BITS;
    f = dc & 255;
    near_tap = ring_model[(wr_ptr + DEPTH - n) % DEPTH];
    // At the longest delay the far tap is the slot about to be overwritten.
    far_tap  = ring_model[(wr_ptr + DEPTH - n - 1) % DEPTH];
    mix = near_tap * (256 - f) + far_tap * f;
    scaled = (mix * longint'(gain_model) + (longint'(1) <<< (ROUND_SHIFT - 1)))
             >>> ROUND_SHIFT;
    res = clip16(scaled);
    ring_model[wr_ptr] = clip16(longint'(x) + longint'(res));
    wr_ptr = (wr_ptr + 1) % DEPTH;
    return res;
  endfunction

  // Mostly short delays so the feedback sees recently written data; the
  // rest hits the clamps, whole-number taps and fully random delay bits.
  function automatic feed_t random_word();
    feed_t w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)
      w.delay = delay_t'($urandom_range(256, 40 * 256 + 255));
    else if (pick < 68)
      w.delay = delay_t'($urandom);
    else if (pick < 76)
      w.delay = delay_t'($urandom_range(0, 255));
    else if (pick < 86)
      w.delay = delay_t'($urandom_range(int'(DELAY_MAX) - 512, 20'hfffff));
    else
      w.delay = {12'($urandom_range(1, 64)), 8'h00};
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3, 4: w.sample = sample_t'($urandom);
      5, 6:          w.sample = sample_t'($urandom_range(0, 511) - 256);
      7:             w.sample = SAMPLE_MAX;
      8:             w.sample = SAMPLE_MIN;
      default:       w.sample = '0;
    endcase
    return w;
  endfunction

  task automatic queue_word(input sample_t s, input delay_t d);
    feed_t w;
    w.sample = s;
    w.delay  = d;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // Wait until every queued word went in and every result came out, then
  // let the pipeline settle before the next register write.
  task automatic drain_results();
    while (!(words_accepted == words_queued && expected_out.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, access cycle, register takes the value at the access edge.
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == GAIN_ADDR) gain_model = data[15:0];
  endtask

  // Input driver: predicts at each accepted word, then draws a gap before
  // presenting the next one. valid gets at most one update per edge.
  always @(posedge clk) begin
    int g;
    feed_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      g = src_gap;
      if (in_ch.valid && in_ch.ready) begin
        expected_out.push_back(tap_blend(in_ch.sample_in, in_ch.delay_samples));
        words_accepted++;
        g = src_idle_en ? $urandom_range(0, 10) : 0;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (g > 0) begin
          g--;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_ch.sample_in     <= w.sample;
          in_ch.delay_samples <= w.delay;
          in_ch.valid         <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      src_gap = g;
    end
  end

  // Result sink ready: random stall per word, plus one long hold-off once
  // enough words went in, so the block backs up and stalls its input.
  always @(posedge clk) begin
    int s;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_stall = 0;
      hold_left  = 0;
    end else begin
      s = sink_stall;
      if (out_ch.valid && out_ch.ready) s = sink_idle_en ? $urandom_range(0, 10) : 0;
      if (!hold_done && words_accepted >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (s > 0) begin
        s--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      sink_stall = s;
    end
  end

  // Result monitor: each accepted word against the oldest prediction.
  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_out.size() == 0) begin
        report_mismatch($sformatf("result word %0d with nothing expected",
                                  out_ch.sample_out));
      end else begin
        want = expected_out.pop_front();
        if (out_ch.sample_out !== want)
          report_mismatch($sformatf("sample_out got %0d want %0d",
                                    out_ch.sample_out, want));
      end
    end
  end

  initial begin
    gain_t phase_gain [NUM_PHASES];
    int    phase_len  [NUM_PHASES];
    feed_t w;

    // Every block input known from time zero.
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.sample_in     = '0;
    in_ch.delay_samples = '0;
    out_ch.ready        = 1'b0;

    foreach (ring_model[i]) ring_model[i] = '0;
    wr_ptr         = 0;
    gain_model     = GAIN_RESET;
    words_queued   = 0;
    words_accepted = 0;
    err_count      = 0;
    src_idle_en    = 1'b1;
    sink_idle_en   = 1'b1;
    hold_done      = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset gain of 1.0.
    queue_word(SAMPLE_MAX, 20'h00000);         // delay below one sample, clamped
    queue_word(SAMPLE_MIN, 20'h000ff);         // just under one sample, clamped
    queue_word(16'sd0, 20'h00100);             // exactly one sample
    queue_word(16'sd100, 20'h00180);           // 1.5 samples, half blend
    queue_word(16'sd1000, 20'h002ff);          // largest fraction
    queue_word(-16'sd1000, 20'h00201);         // smallest fraction
    queue_word(16'sd0, 20'hfffff);             // far beyond the ring, clamped
    queue_word(16'sd0, delay_t'(DELAY_MAX));   // longest legal delay
    queue_word(16'sd1, delay_t'(DELAY_MAX + 1));
    queue_word(16'sd0, delay_t'(DELAY_MAX - 1));
    queue_word(SAMPLE_MAX, 20'h00100);         // write-back saturates high
    queue_word(SAMPLE_MAX, 20'h00100);
    queue_word(SAMPLE_MIN, 20'h00300);         // whole-number delay of 3
    queue_word(SAMPLE_MIN, 20'h00100);
    queue_word(-16'sd1, 20'h00080);            // fraction-only delay, clamped
    queue_word(16'sd12345, 20'h00a40);
    queue_word(-16'sd12345, 20'h55555);
    queue_word(16'sd0, 20'haaaaa);
    drain_results();

    // A write to an unmapped word must leave the gain alone.
    cfg_write(SPARE_ADDR, $urandom);
    queue_word(16'sd77, 20'h00100);
    queue_word(16'sd0, 20'h00100);
    drain_results();

    phase_gain = '{16'd16384, 16'hffff, 16'd0, 16'd1, 16'd8192, 16'd49152, 16'd0};
    phase_gain[NUM_PHASES - 1] = gain_t'($urandom);
    phase_len  = '{70, 65, 70, 50, 70, 60, 65};

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Mix of idling on both sides, one side only, and none at all.
      src_idle_en  = (p % 3) != 1 && p != 4;
      sink_idle_en = (p % 3) != 2 && p != 4;
      cfg_write(GAIN_ADDR, {16'h0000, phase_gain[p]});
      if (phase_gain[p] == 16'hffff) begin
        // Gain near 4.0 on full-scale taps: output saturates both ways.
        queue_word(SAMPLE_MAX, 20'h00100);
        queue_word(SAMPLE_MAX, 20'h00100);
        queue_word(SAMPLE_MIN, 20'h00100);
        queue_word(SAMPLE_MIN, 20'h00100);
      end
      repeat (phase_len[p]) begin
        w = random_word();
        queue_word(w.sample, w.delay);
      end
      drain_results();
    end

    if (err_count == 0) begin
      $display("tb_fractional_feedback_delay_line: clean");
    end else begin
      $display("tb_fractional_feedback_delay_line: errors");
    end
    $finish;
  end

endmodule
